// ----- rtl/q24_pkg.sv -----
// ----------------------------------------------------------------------------
// q24_pkg: shared types and codes of the Q24.8 format converter
// Holds the opcode and status codes and the request and response structs.
// ----------------------------------------------------------------------------
package q24_pkg;

    localparam logic [2:0] OP_INT_TO_FIX   = 3'd0;
    localparam logic [2:0] OP_FLT_TO_FIX   = 3'd1;
    localparam logic [2:0] OP_FIX_TO_INT   = 3'd2;
    localparam logic [2:0] OP_FIX_TO_INT_R = 3'd3;
    localparam logic [2:0] OP_FIX_TO_FLT   = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NAN = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] operand;
    } q24_req_t;

    typedef struct packed {
        logic [31:0] result;
        logic [1:0]  status;
    } q24_rsp_t;

endpackage

// ----- rtl/q24_convert.sv -----
// ----------------------------------------------------------------------------
// q24_convert: combinational conversion datapath
// Computes one result word and status from an opcode and operand.
// ----------------------------------------------------------------------------
module q24_convert
    import q24_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  q24_req_t req,
    output q24_rsp_t rsp
);

    localparam int FB = FRACTION_BITS;

    // int to fixed
    logic        i2f_ovf;
    logic [31:0] i2f_val;

    // float to fixed
    logic        f_neg;
    logic [7:0]  f_ex;
    logic [23:0] f_m;
    logic [9:0]  f_sh;      // signed shift: exponent - 150 + FB
    logic [9:0]  f_r;
    logic [63:0] f_q;
    logic [63:0] f_wide;
    logic        f_big;
    logic        f_ovf;
    logic [31:0] f2x_val;
    logic [1:0]  f2x_st;

    // fixed to int / float
    logic        x_neg;
    logic [31:0] x_mag;
    logic [31:0] x_trunc;
    logic [31:0] x_rnd;
    logic [4:0]  x_p;
    logic [31:0] x_norm;
    logic [24:0] x_mant;
    logic        x_guard;
    logic        x_sticky;
    logic        x_up;
    logic [8:0]  x_exp;
    logic [31:0] x_flt;

    always_comb
    begin
        i2f_ovf = ($signed(req.operand) > $signed(32'((64'sd1 <<< (31 - FB)) - 1)))
               || ($signed(req.operand) < $signed(32'(-(64'sd1 <<< (31 - FB)))));
        i2f_val = req.operand << FB;
    end

    always_comb
    begin
        f_neg = req.operand[31];
        f_ex  = req.operand[30:23];
        f_m   = (f_ex == 8'd0) ? {1'b0, req.operand[22:0]} : {1'b1, req.operand[22:0]};
        f_sh  = ((f_ex == 8'd0) ? 10'd1 : {2'b0, f_ex}) - 10'd150 + 10'(FB);
        f_r   = 10'd0 - f_sh;
        f_big = 1'b0;
        f_q   = '0;
        f_wide = {40'b0, f_m};
        if (f_m == 24'd0)
        begin
            f_q = '0;
        end
        else if (!f_sh[9])
        begin
            if (f_sh > 10'd40)
            begin
                f_big = 1'b1;
            end
            else
            begin
                f_q = f_wide << f_sh[5:0];
            end
        end
        else if (f_r <= 10'd25)
        begin
            f_q = (f_wide + (64'd1 << (f_r[4:0] - 5'd1))) >> f_r[4:0];
        end
        f_ovf = f_big || (!f_neg && f_q > 64'h7FFF_FFFF)
                      || (f_neg && f_q > 64'h8000_0000);
        if (f_ex == 8'hFF)
        begin
            f2x_st  = (req.operand[22:0] != 23'd0) ? ST_NAN : ST_OVF;
            f2x_val = '0;
        end
        else if (f_ovf)
        begin
            f2x_st  = ST_OVF;
            f2x_val = '0;
        end
        else
        begin
            f2x_st  = ST_OK;
            f2x_val = f_neg ? 32'd0 - f_q[31:0] : f_q[31:0];
        end
    end

    always_comb
    begin
        x_neg   = req.operand[31];
        x_mag   = x_neg ? 32'd0 - req.operand : req.operand;
        x_trunc = x_mag >> FB;
        x_rnd   = x_trunc + {31'b0, x_mag[FB-1]};
        // leading one position
        x_p = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x_mag[i])
            begin
                x_p = 5'(i);
            end
        end
        x_norm   = x_mag << (5'd31 - x_p);
        x_guard  = x_norm[7];
        x_sticky = |x_norm[6:0];
        x_up     = x_guard && (x_sticky || x_norm[8]);
        x_mant   = {1'b0, x_norm[31:8]} + {24'b0, x_up};
        x_exp    = 9'({4'b0, x_p} + 9'd127 - 9'(FB)) + {8'b0, x_mant[24]};
        x_flt    = (x_mag == 32'd0) ? 32'd0
                 : {x_neg, x_exp[7:0],
                    x_mant[24] ? x_mant[23:1] : x_mant[22:0]};
    end

    always_comb
    begin
        rsp.result = '0;
        rsp.status = ST_OK;
        case (req.opcode)
            OP_INT_TO_FIX:
            begin
                rsp.status = i2f_ovf ? ST_OVF : ST_OK;
                rsp.result = i2f_ovf ? 32'd0 : i2f_val;
            end
            OP_FLT_TO_FIX:
            begin
                rsp.status = f2x_st;
                rsp.result = f2x_val;
            end
            OP_FIX_TO_INT:   rsp.result = x_neg ? 32'd0 - x_trunc : x_trunc;
            OP_FIX_TO_INT_R: rsp.result = x_neg ? 32'd0 - x_rnd : x_rnd;
            OP_FIX_TO_FLT:   rsp.result = x_flt;
            default:
            begin
                rsp.result = '0;
                rsp.status = ST_OK;
            end
        endcase
    end

endmodule

// ----- rtl/q24_8_format_converter.sv -----
// ----------------------------------------------------------------------------
// q24_8_format_converter: Q24.8 fixed-point format converter
// Converts between integers, IEEE single and fixed-point words.
// ----------------------------------------------------------------------------
// On the way from start to done, the request is
// captured in an input register, converted by the single-pass datapath, and
// the result is registered and shown with done high for one cycle. busy is
// never raised, so a new transaction can start every cycle and results come
// out in order at one per cycle. The receiver cannot stall the output.
module q24_8_format_converter
    import q24_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  q24_req_t req,
    output logic     done,
    output q24_rsp_t rsp
);

    logic     in_vld_reg;
    q24_req_t in_reg;
    logic     out_vld_reg;
    q24_rsp_t out_reg;
    q24_rsp_t conv_next;

    q24_convert #(.FRACTION_BITS(FRACTION_BITS)) u_conv
    (
        .req (in_reg),
        .rsp (conv_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= req;
        end
        if (in_vld_reg)
        begin
            out_reg <= conv_next;
        end
    end

    assign busy = 1'b0;
    assign done = out_vld_reg;
    assign rsp  = out_reg;

endmodule

// ----- dv/q24_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24_checker: result checker of the Q24.8 format converter
// Watches accepted requests, predicts each response and compares it with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module q24_checker
    import q24_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  q24_req_t req,
    input  logic     done,
    input  q24_rsp_t rsp,
    output int       fail_count,
    output int       pending
);

    q24_rsp_t expected_rsps[$];

    function automatic logic [31:0] negate(input logic [31:0] v);
        negate = 32'd0 - v;
    endfunction

    function automatic q24_rsp_t convert(input q24_req_t r);
        q24_rsp_t   o;
        logic [31:0] op;
        logic        neg;
        logic [7:0]  ex;
        logic [63:0] m;
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        longint      v;
        longint      lim;
        int          sh;
        int          p;
        op = r.operand;
        o.result = 32'd0;
        o.status = ST_OK;
        neg = op[31];
        a = neg ? {32'd0, negate(op)} : {32'd0, op};
        if (op == 32'h8000_0000)
            a = 64'h8000_0000;
        case (r.opcode)
            OP_INT_TO_FIX:
            begin
                v = longint'($signed(op));
                lim = longint'(1) << (31 - FRACTION_BITS);
                if (v > lim - 1 || v < -lim)
                    o.status = ST_OVF;
                else
                    o.result = op << FRACTION_BITS;
            end
            OP_FLT_TO_FIX:
            begin
                ex = op[30:23];
                m = {41'd0, op[22:0]};
                if (ex == 8'hFF)
                begin
                    o.status = (m != 0) ? ST_NAN : ST_OVF;
                end
                else
                begin
                    if (ex == 0)
                        sh = 1 - 150 + FRACTION_BITS;
                    else
                    begin
                        sh = int'(ex) - 150 + FRACTION_BITS;
                        m[23] = 1'b1;
                    end
                    if (m == 0)
                        q = 0;
                    else if (sh > 40)
                        q = 64'hFFFF_FFFF_FFFF;
                    else if (sh >= 0)
                        q = m << sh;
                    else if (-sh > 25)
                        q = 0;
                    else
                        q = (m + (64'd1 << (-sh - 1))) >> (-sh);
                    if ((!neg && q > 64'h7FFF_FFFF) || (neg && q > 64'h8000_0000))
                        o.status = ST_OVF;
                    else
                        o.result = neg ? negate(q[31:0]) : q[31:0];
                end
            end
            OP_FIX_TO_INT, OP_FIX_TO_INT_R:
            begin
                q = a >> FRACTION_BITS;
                if (r.opcode == OP_FIX_TO_INT_R && a[FRACTION_BITS-1])
                    q = q + 1;
                o.result = neg ? negate(q[31:0]) : q[31:0];
            end
            OP_FIX_TO_FLT:
            begin
                if (a != 0)
                begin
                    p = 0;
                    while ((a >> (p + 1)) != 0)
                        p++;
                    if (p > 23)
                    begin
                        rem = a & ((64'd1 << (p - 23)) - 1);
                        half = 64'd1 << (p - 24);
                        q = a >> (p - 23);
                        if (rem > half || (rem == half && q[0]))
                            q = q + 1;
                        if (q[24])
                        begin
                            q = q >> 1;
                            p++;
                        end
                    end
                    else
                        q = a << (23 - p);
                    ex = 8'(p - FRACTION_BITS + 127);
                    o.result = {neg, ex, q[22:0]};
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    assign pending = expected_rsps.size();

    always @(posedge clk or negedge rst_n)
    begin
        q24_rsp_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response result=%h status=%0d", rsp.result, rsp.status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.result !== want.result || rsp.status !== want.status)
                    begin
                        if (rsp.result !== want.result)
                            $error("result: expected %h actual %h", want.result, rsp.result);
                        if (rsp.status !== want.status)
                            $error("status: expected %0d actual %0d", want.status, rsp.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // predict after the pop so a same-cycle response sees older entries only
            if (start && !busy)
                expected_rsps.push_back(convert(req));
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Q24.8 format converter
// Drives directed corner cases and bursty random requests of every opcode;
// the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
    import q24_pkg::*;

    localparam int LIMIT_CYCLES = 200000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    logic     done;
    q24_req_t req = '0;
    q24_rsp_t rsp;
    int       fail_count;
    int       pending;
    int       cycles = 0;

    q24_8_format_converter dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    q24_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // hold start until the transaction is taken
    task automatic send(input logic [2:0] opc, input logic [31:0] opnd);
        start <= 1'b1;
        req <= '{opcode: opc, operand: opnd};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic go_idle(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v = $signed(v) >>> $urandom_range(0, 31);
            1: v = {v[31], 8'($urandom_range(100, 175)), v[22:0]};
            2: v[7:0] = {1'b1, 7'd0} | ($urandom_range(0, 1) ? v[7:0] & 8'h80 : 8'h80);
            3: v = {v[31], 8'hFF, ($urandom_range(0, 1) ? 23'd0 : v[22:0])};
            4: v = {v[31], 8'd0, v[22:0]};
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] corners[] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h007F_FFFF, 32'hFF80_0000, 32'h0080_0000,
            32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0001, 32'h7FC0_0000,
            32'h8000_0080, 32'h0000_0180, 32'h4EFF_FFFF, 32'hCF00_0000,
            32'h3B00_0000, 32'h3B80_0000, 32'h0000_0001, 32'h8000_0000};
        int n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 5; i++)
            send(3'(i), corners[$urandom_range(0, corners.size() - 1)]);
        foreach (corners[i])
            send(3'($urandom_range(0, 7)), corners[i]);
        // drain completely once
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        n = 0;
        while (n < 2000)
        begin
            logic [2:0] opc;
            for (int b = $urandom_range(1, 40); b > 0 && n < 2000; b--)
            begin
                opc = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
                send(opc, rand_operand());
                n++;
            end
            if ($urandom_range(0, 3) != 0)
                go_idle($urandom_range(1, 8));
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
